// File: design/rdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  localparam int DB_TABLE_DEPTH_DEF = 256;
  localparam int CHANNEL_COUNT_DEF  = 2;

  localparam logic [16:0] UNITY         = 17'd65536;
  localparam logic [16:0] NEAR_UNITY    = 17'd64881;
  localparam logic [17:0] ATTACK_MARGIN = 18'd328;
  localparam logic [63:0] Y_PER_32DB    = 64'd89172328;
  // ceil(2^34 / 125), exact floor division for quotients below 2^27
  localparam logic [27:0] RECIP_125     = 28'd137438954;

  localparam logic [31:0] HALF_STEPS [12] = '{
    32'd759250125, 32'd902905651, 32'd984625594, 32'd1028218693,
    32'd1050733751, 32'd1062175491, 32'd1067942999, 32'd1070838486,
    32'd1072289172, 32'd1073015252, 32'd1073378477, 32'd1073560135
  };

  typedef enum logic [2:0] {
    CFG_ENV_ATTACK  = 3'd0,
    CFG_ENV_RELEASE = 3'd1,
    CFG_GAIN_ATTACK = 3'd2,
    CFG_GAIN_RELEASE = 3'd3,
    CFG_SAMPLE_RATE = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_COOLDOWN = 3'd1,
    PH_ATTACK   = 3'd2,
    PH_HOLD     = 3'd3,
    PH_RELEASE  = 3'd4
  } phase_e;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [10:0]        amount;
    logic [15:0]        random_drop;
    logic [15:0]        random_time;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [16:0]        gain_level;
    logic [2:0]         phase;
  } out_t;

endpackage

`default_nettype wire

// File: design/rdc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_mul (
  input  wire logic               clk_i,
  input  wire logic signed [28:0] a_i,
  input  wire logic signed [28:0] b_i,
  output logic signed [57:0]      p_o
);

  logic signed [57:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: design/rdc_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_rom
  import rdc_pkg::*;
#(
  parameter int DEPTH = DB_TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic [AW-1:0] addr_i,
  output logic [16:0]        data_o
);

  typedef logic [16:0] rom_t [DEPTH + 1];

  // gain = 2^-y, y = dB*log2(10)/20, built from 12 fractional half steps
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] y;
    logic [63:0] v;
    logic [31:0] whole;
    logic [31:0] frac;
    for (int i = 0; i <= DEPTH; i++) begin
      y     = (64'(i) * Y_PER_32DB) / DEPTH;
      whole = 32'(y >> 24);
      frac  = 32'((y >> 12) & 64'hFFF);
      v     = 64'd1 << 30;
      for (int k = 0; k < 12; k++) begin
        if (frac[11-k]) begin
          v = (v * 64'(HALF_STEPS[k]) + (64'd1 << 29)) >> 30;
        end
      end
      if (whole > 32'd30) whole = 32'd30;
      v    = v >> whole;
      r[i] = 17'((v + 64'd8192) >> 14);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [16:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: design/random_dropout_compressor.sv
`timescale 1ns / 1ps
`default_nettype none

// Random dropout compressor: one stereo Q1.15 sample per request. Above half
// amount a peak envelope is compared with a dB threshold and a crossing runs
// attack, hold, release and cooldown with random depth and lengths; both
// channels are scaled by the Q1.16 gain. All multiplies go through a single
// registered 29x29 multiplier under a one-hot sequencer, with a registered
// dB-to-gain ROM. A request at half amount or below takes the short path, with
// a gain smoothing step while the gain relaxes toward unity; above half amount
// it also runs the envelope and threshold, and may add a gain smoothing step,
// trigger a cycle or draw a hold or cooldown length. in_stall_o is high while
// a request is in work, so no new request is taken before the last is through;
// a finished result waits in the output register, and a stalled output holds
// the sequencer until the register is free.
module random_dropout_compressor
  import rdc_pkg::*;
#(
  parameter int DB_TABLE_DEPTH = DB_TABLE_DEPTH_DEF,
  parameter int CHANNEL_COUNT  = CHANNEL_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o
);

  localparam int AW = $clog2(DB_TABLE_DEPTH + 1);
  localparam logic [39:0] TI_BASE = 40'(1536 * DB_TABLE_DEPTH + 1024);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_ENV   = 21'h000002,
    S_ENVW  = 21'h000004,
    S_THR   = 21'h000008,
    S_THRW  = 21'h000010,
    S_ATT   = 21'h000020,
    S_IDX   = 21'h000040,
    S_IDXW  = 21'h000080,
    S_PHASE = 21'h000100,
    S_GMUL  = 21'h000200,
    S_GSM   = 21'h000400,
    S_D1    = 21'h000800,
    S_D2    = 21'h001000,
    S_D3    = 21'h002000,
    S_D4    = 21'h004000,
    S_D5    = 21'h008000,
    S_SCL   = 21'h010000,
    S_SCR   = 21'h020000,
    S_SCW   = 21'h040000,
    S_OUT   = 21'h080000,
    S_SPARE = 21'h100000
  } state_e;

  state_e state_q;

  logic [23:0] env_att_q, env_rel_q, g_att_q, g_rel_q;
  logic [17:0] rate_q;

  logic [23:0] env_q;
  logic [16:0] gain_q, tgt_q;
  logic [17:0] hold_q, cool_q;
  logic        act_q, hld_q, rel_q;

  logic signed [15:0] ls_q, rs_q, lo_q, ro_q;
  logic [15:0] rdrop_q, rtime_q;
  logic [9:0]  t_q;
  logic        gated_q;
  logic [16:0] num_q;
  logic [17:0] plsh_q;
  logic        out_valid_q;
  out_t        out_q;

  logic signed [28:0] mul_a, mul_b;
  logic signed [57:0] prod;
  logic [AW-1:0]      rom_addr;
  logic [16:0]        rom_data;

  rdc_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  rdc_rom #(.DEPTH(DB_TABLE_DEPTH), .AW(AW)) u_rom (
    .clk_i(clk_i), .addr_i(rom_addr), .data_o(rom_data)
  );

  // detector level and envelope direction
  logic [16:0] abs_l, abs_r, abs_m;
  logic [23:0] level;
  logic        env_up;
  always_comb begin
    abs_l  = ls_q[15] ? 17'(-{ls_q[15], ls_q}) : 17'(ls_q);
    abs_r  = rs_q[15] ? 17'(-{rs_q[15], rs_q}) : 17'(rs_q);
    abs_m  = (abs_r > abs_l) ? abs_r : abs_l;
    level  = 24'(abs_m) << 8;
    env_up = level > env_q;
  end

  // rounded smoothing term, (c*(y-x) + 2^23) >>> 24
  logic signed [57:0] rnd_full;
  logic signed [24:0] rnd;
  assign rnd_full = (prod + 58'sd8388608) >>> 24;
  assign rnd      = rnd_full[24:0];

  logic        gsm_rel;
  logic [16:0] gsm_x;
  logic [23:0] gsm_c;
  assign gsm_rel = !gated_q || rel_q;
  assign gsm_x   = gsm_rel ? UNITY : tgt_q;
  assign gsm_c   = gsm_rel ? g_rel_q : g_att_q;

  logic signed [24:0] n_raw;
  logic [16:0]        n_gain;
  always_comb begin
    n_raw  = $signed({8'b0, gsm_x}) + rnd;
    n_gain = n_raw[16:0];
    // stalled smoothing still moves one LSB toward the target
    if (n_gain == gain_q && gain_q != gsm_x) begin
      n_gain = (gain_q < gsm_x) ? gain_q + 17'd1 : gain_q - 17'd1;
    end
  end

  logic [12:0] dlo;
  logic [18:0] dspan;
  logic [34:0] num_c;
  logic [26:0] quo;
  logic [17:0] drawn;
  logic [26:0] att;
  logic [39:0] ti, idx;
  logic signed [57:0] sc_full;
  logic [15:0] sc;
  assign dlo     = 13'd5120 - 13'(t_q) * 13'd5;
  assign dspan   = 19'd378880 - 19'(t_q) * 19'd695;
  assign num_c   = (35'(dlo) << 16) + 35'(prod[34:0]);
  assign quo     = 27'((40'(prod[35:0]) + 40'(plsh_q)) >> 10);
  assign drawn   = prod[51:34];
  assign att     = 27'd4194304 + 27'(prod[25:0]);
  assign ti      = (40'(prod[39:0]) + TI_BASE) >> 11;
  assign idx     = (40'(prod[39:0]) + 40'd67108864) >> 27;
  assign sc_full = (prod + 58'sd32768) >>> 16;
  assign sc      = sc_full[15:0];

  always_comb begin
    rom_addr = '0;
    if (state_q == S_THR) begin
      rom_addr = (ti > 40'(DB_TABLE_DEPTH)) ? AW'(DB_TABLE_DEPTH) : ti[AW-1:0];
    end else if (state_q == S_IDX) begin
      rom_addr = (idx > 40'(DB_TABLE_DEPTH)) ? AW'(DB_TABLE_DEPTH) : idx[AW-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ENV: begin
        mul_a = 29'(env_up ? env_att_q : env_rel_q);
        mul_b = 29'($signed({1'b0, env_q}) - $signed({1'b0, level}));
      end
      S_ENVW: begin
        mul_a = 29'(t_q);
        mul_b = 29'(DB_TABLE_DEPTH);
      end
      S_THRW: begin
        mul_a = 29'(rdrop_q);
        mul_b = 29'(10'd192 + t_q);
      end
      S_ATT: begin
        mul_a = 29'(att);
        mul_b = 29'(DB_TABLE_DEPTH);
      end
      S_GMUL: begin
        mul_a = 29'(gsm_c);
        mul_b = 29'($signed({1'b0, gain_q}) - $signed({1'b0, gsm_x}));
      end
      S_D1: begin
        mul_a = 29'(rtime_q);
        mul_b = 29'(dspan);
      end
      S_D2: begin
        mul_a = 29'(num_c[17:0]);
        mul_b = 29'(rate_q);
      end
      S_D3: begin
        mul_a = 29'(num_q);
        mul_b = 29'(rate_q);
      end
      S_D4: begin
        mul_a = 29'(quo);
        mul_b = 29'(RECIP_125);
      end
      S_SCL: begin
        mul_a = 29'(ls_q);
        mul_b = 29'(gain_q);
      end
      S_SCR: begin
        mul_a = 29'(rs_q);
        mul_b = 29'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic [2:0] phase_c;
  always_comb begin
    if (act_q) begin
      phase_c = hld_q ? PH_HOLD : (rel_q ? PH_RELEASE : PH_ATTACK);
    end else begin
      phase_c = (cool_q != '0) ? PH_COOLDOWN : PH_IDLE;
    end
  end

  logic [10:0] amt_c;
  assign amt_c = (in_data_i.amount > 11'd1024) ? 11'd1024 : in_data_i.amount;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_att_q <= 24'd16431940;
      env_rel_q <= 24'd16775818;
      g_att_q   <= 24'd16707456;
      g_rel_q   <= 24'd16742298;
      rate_q    <= 18'd48000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENV_ATTACK:   env_att_q <= cfg_data_i;
        CFG_ENV_RELEASE:  env_rel_q <= cfg_data_i;
        CFG_GAIN_ATTACK:  g_att_q   <= cfg_data_i;
        CFG_GAIN_RELEASE: g_rel_q   <= cfg_data_i;
        CFG_SAMPLE_RATE:  rate_q    <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      ls_q    <= in_data_i.left_sample;
      rs_q    <= (CHANNEL_COUNT > 1) ? in_data_i.right_sample : 16'sd0;
      lo_q    <= in_data_i.left_sample;
      ro_q    <= (CHANNEL_COUNT > 1) ? in_data_i.right_sample : 16'sd0;
      rdrop_q <= in_data_i.random_drop;
      rtime_q <= in_data_i.random_time;
      t_q     <= 10'(amt_c - 11'd512);
    end
    if (state_q == S_D2) num_q <= num_c[34:18];
    if (state_q == S_D3) plsh_q <= prod[35:18];
    if (state_q == S_SCR) lo_q <= sc;
    if (state_q == S_SCW) ro_q <= sc;
    if (state_q == S_OUT && !(out_valid_q && out_stall_i)) begin
      out_q.left_out   <= lo_q;
      out_q.right_out  <= ro_q;
      out_q.gain_level <= gain_q;
      out_q.phase      <= phase_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      env_q       <= '0;
      gain_q      <= UNITY;
      tgt_q       <= UNITY;
      hold_q      <= '0;
      cool_q      <= '0;
      act_q       <= 1'b0;
      hld_q       <= 1'b0;
      rel_q       <= 1'b0;
      gated_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            gated_q <= amt_c > 11'd512;
            if (amt_c > 11'd512) state_q <= S_ENV;
            else if (gain_q < NEAR_UNITY) state_q <= S_GMUL;
            else state_q <= S_OUT;
          end
        end
        S_ENV:  state_q <= S_ENVW;
        S_ENVW: begin
          env_q   <= level + 24'(rnd);
          state_q <= S_THR;
        end
        S_THR:  state_q <= S_THRW;
        S_THRW: begin
          if (cool_q != '0) begin
            cool_q  <= cool_q - 18'd1;
            state_q <= S_PHASE;
          end else if (!act_q && env_q > {rom_data, 7'b0}) begin
            state_q <= S_ATT;
          end else begin
            state_q <= S_PHASE;
          end
        end
        S_ATT:  state_q <= S_IDX;
        S_IDX:  state_q <= S_IDXW;
        S_IDXW: begin
          tgt_q   <= rom_data;
          act_q   <= 1'b1;
          hld_q   <= 1'b0;
          rel_q   <= 1'b0;
          state_q <= S_PHASE;
        end
        S_PHASE: begin
          if (act_q && hld_q) begin
            gain_q <= tgt_q;
            if (hold_q <= 18'd1) begin
              hold_q <= '0;
              hld_q  <= 1'b0;
              rel_q  <= 1'b1;
            end else begin
              hold_q <= hold_q - 18'd1;
            end
            state_q <= S_SCL;
          end else if (act_q) begin
            state_q <= S_GMUL;
          end else begin
            state_q <= S_SCL;
          end
        end
        S_GMUL: state_q <= S_GSM;
        S_GSM: begin
          if (!gated_q) begin
            gain_q  <= n_gain;
            state_q <= S_OUT;
          end else if (rel_q) begin
            if (n_gain >= NEAR_UNITY) begin
              gain_q  <= UNITY;
              act_q   <= 1'b0;
              rel_q   <= 1'b0;
              state_q <= S_D1;
            end else begin
              gain_q  <= n_gain;
              state_q <= S_SCL;
            end
          end else begin
            if (18'(n_gain) <= 18'(tgt_q) + ATTACK_MARGIN) begin
              gain_q  <= tgt_q;
              hld_q   <= 1'b1;
              state_q <= S_D1;
            end else begin
              gain_q  <= n_gain;
              state_q <= S_SCL;
            end
          end
        end
        S_D1: state_q <= S_D2;
        S_D2: state_q <= S_D3;
        S_D3: state_q <= S_D4;
        S_D4: state_q <= S_D5;
        S_D5: begin
          if (act_q) hold_q <= drawn;
          else cool_q <= drawn;
          state_q <= S_SCL;
        end
        S_SCL: state_q <= S_SCR;
        S_SCR: state_q <= S_SCW;
        S_SCW: state_q <= S_OUT;
        S_OUT: begin
          if (!(out_valid_q && out_stall_i)) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/rdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_checker
  import rdc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gain_level <= UNITY)
    else $error("gain above unity");

  // outside an active cycle the gain has been snapped back to unity
  a_idle_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.phase == PH_IDLE || out_data_o.phase == PH_COOLDOWN)
    |-> out_data_o.gain_level == UNITY)
    else $error("gain not unity while inactive");

endmodule

bind random_dropout_compressor rdc_checker u_rdc_checker (.*);

`default_nettype wire
